// ----- design/mpe_pkg.sv -----
// Shared types, constants and helpers for the Mandelbrot pixel escape block.
// Used by mpe_regs and mandelbrot_pixel_escape_top; depends on nothing else.
package mpe_pkg;

  // Width of the internal plane values, and how a product operand is split.
  localparam int IW     = 40;
  localparam int HALF   = 20;
  localparam int BW     = 21;
  localparam int PPW    = IW + BW;
  localparam int PW     = 2 * IW;
  localparam int CFG_W  = 32;
  localparam int DIM_W  = 13;
  localparam int LIM_W  = 16;
  localparam int DIV_VW = 16;
  localparam int ADDR_W = 5;

  typedef logic signed [IW-1:0] inner_t;

  localparam inner_t SAT_HI = {1'b0, {(IW-1){1'b1}}};
  localparam inner_t SAT_LO = {1'b1, {(IW-1){1'b0}}};

  localparam logic [CFG_W-1:0] RST_REAL_MIN     = 32'hE000_0000;
  localparam logic [CFG_W-1:0] RST_REAL_MAX     = 32'h1000_0000;
  localparam logic [CFG_W-1:0] RST_IMAG_MIN     = 32'hE800_0000;
  localparam logic [CFG_W-1:0] RST_IMAG_MAX     = 32'h1800_0000;
  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd1024;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd768;
  localparam logic [LIM_W-1:0] RST_ITER_LIMIT   = 16'd256;

  typedef struct packed {
    logic signed [CFG_W-1:0] real_min;
    logic signed [CFG_W-1:0] real_max;
    logic signed [CFG_W-1:0] imag_min;
    logic signed [CFG_W-1:0] imag_max;
    logic [DIM_W-1:0]        image_width;
    logic [DIM_W-1:0]        image_height;
    logic [LIM_W-1:0]        iteration_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_REAL_MIN,
    REG_REAL_MAX,
    REG_IMAG_MIN,
    REG_IMAG_MAX,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_ITER_LIMIT
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_MUL,
    ST_MAP_DIV,
    ST_MAP_WAIT,
    ST_ITER,
    ST_SCALE,
    ST_SCALE_WAIT
  } state_e;

  // One iteration is eight steps, six of them passes over the shared multiplier.
  typedef enum logic [2:0] {
    STEP_RR_LO,
    STEP_RR_HI,
    STEP_II_LO,
    STEP_II_HI,
    STEP_RI_LO,
    STEP_RI_HI,
    STEP_RI_DONE,
    STEP_UPDATE
  } step_e;

  // Saturates a sum of a few plane values back to the inner width.
  function automatic inner_t sat_step(input logic signed [IW+1:0] v);
    logic signed [IW+1:0] hi;
    logic signed [IW+1:0] lo;
    hi = {2'b00, SAT_HI};
    lo = {2'b11, SAT_LO};
    if (v > hi) begin
      return SAT_HI;
    end else if (v < lo) begin
      return SAT_LO;
    end
    return v[IW-1:0];
  endfunction

endpackage

// ----- design/mpe_regs.sv -----
// Configuration register file with an APB-style write/read port.
// Depends on mpe_pkg for the register map, reset values and cfg_t.
module mpe_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mpe_pkg::ADDR_W-1:0]  paddr,
  input  logic [mpe_pkg::CFG_W-1:0]   pwdata,
  output logic [mpe_pkg::CFG_W-1:0]   prdata,
  output logic                        pready,
  output mpe_pkg::cfg_t               cfg_o
);

  mpe_pkg::cfg_t    cfg_q;
  mpe_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = mpe_pkg::reg_idx_e'(paddr[mpe_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.real_min        <= mpe_pkg::RST_REAL_MIN;
      cfg_q.real_max        <= mpe_pkg::RST_REAL_MAX;
      cfg_q.imag_min        <= mpe_pkg::RST_IMAG_MIN;
      cfg_q.imag_max        <= mpe_pkg::RST_IMAG_MAX;
      cfg_q.image_width     <= mpe_pkg::RST_IMAGE_WIDTH;
      cfg_q.image_height    <= mpe_pkg::RST_IMAGE_HEIGHT;
      cfg_q.iteration_limit <= mpe_pkg::RST_ITER_LIMIT;
    end else if (wr_en) begin
      case (idx)
        mpe_pkg::REG_REAL_MIN:     cfg_q.real_min        <= pwdata;
        mpe_pkg::REG_REAL_MAX:     cfg_q.real_max        <= pwdata;
        mpe_pkg::REG_IMAG_MIN:     cfg_q.imag_min        <= pwdata;
        mpe_pkg::REG_IMAG_MAX:     cfg_q.imag_max        <= pwdata;
        mpe_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width     <= pwdata[mpe_pkg::DIM_W-1:0];
        mpe_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height    <= pwdata[mpe_pkg::DIM_W-1:0];
        mpe_pkg::REG_ITER_LIMIT:   cfg_q.iteration_limit <= pwdata[mpe_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mpe_pkg::REG_REAL_MIN:     prdata = cfg_q.real_min;
      mpe_pkg::REG_REAL_MAX:     prdata = cfg_q.real_max;
      mpe_pkg::REG_IMAG_MIN:     prdata = cfg_q.imag_min;
      mpe_pkg::REG_IMAG_MAX:     prdata = cfg_q.imag_max;
      mpe_pkg::REG_IMAGE_WIDTH:
        prdata = {{(mpe_pkg::CFG_W-mpe_pkg::DIM_W){1'b0}}, cfg_q.image_width};
      mpe_pkg::REG_IMAGE_HEIGHT:
        prdata = {{(mpe_pkg::CFG_W-mpe_pkg::DIM_W){1'b0}}, cfg_q.image_height};
      mpe_pkg::REG_ITER_LIMIT:
        prdata = {{(mpe_pkg::CFG_W-mpe_pkg::LIM_W){1'b0}}, cfg_q.iteration_limit};
      default:                   prdata = '0;
    endcase
  end

endmodule

// ----- design/mpe_mul.sv -----
// Shared signed multiplier with a registered product.
// Stand-alone; the sequencer in the top level feeds it one operand pair per beat while en_i is high.
module mpe_mul #(
  parameter int AW = 40,
  parameter int BW = 21
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [AW-1:0]     a_i,
  input  logic signed [BW-1:0]     b_i,
  output logic signed [AW+BW-1:0]  p_o
);

  logic signed [AW+BW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// ----- design/mpe_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Stand-alone; used for both the view mapping and the grey-level scaling.
module mpe_div #(
  parameter int DW = 45,
  parameter int VW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int CNTW = $clog2(DW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW-1:0]   quo_q;
  logic [VW-1:0]   rem_q;
  logic [VW-1:0]   den_q;
  logic [VW:0]     trial;
  logic [VW:0]     diff;
  logic            fits;

  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNTW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], fits};
      rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- design/mandelbrot_pixel_escape_top.sv -----
// Top level of the Mandelbrot escape-time pixel block: sequencer and datapath.
// Depends on mpe_pkg, mpe_regs, mpe_mul and mpe_div.
//
// Usage: the view (real/imaginary edges in signed fixed point), the image size
// and the iteration limit are set through the APB-style port; a write lands at
// the access beat, and reads return the stored value. pready is always high.
// A pixel beat is taken on a rising edge with start high and busy low. The
// block then holds busy high while it maps the pixel into the plane, iterates
// z = z*z + c and scales the escape count. The grey level appears on
// grey_level_o, flagged by done_o for exactly one cycle; busy is low in that
// same cycle, so the next pixel can already be started. The receiver cannot
// stall the result, and none is needed: the result sits in an output register.
//
// Datapath, with DW = DIM_BITS + 33 (45 by default): each axis is mapped with
// one product and a run of the shared divider on a DW-bit dividend, every
// iteration squares and cross-multiplies z on the shared 40 x 21 multiplier,
// and the final scaling takes another divider run for an escaping pixel; a
// pixel that reaches the limit skips it. One pixel is in flight at a time.
// Reset loads the documented default view and clears the sequencer to idle.
module mandelbrot_pixel_escape_top #(
  parameter int FRAC_BITS = 28,
  parameter int DIM_BITS  = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mpe_pkg::ADDR_W-1:0]  paddr,
  input  logic [mpe_pkg::CFG_W-1:0]   pwdata,
  output logic [mpe_pkg::CFG_W-1:0]   prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [DIM_BITS-1:0]         pixel_col_i,
  input  logic [DIM_BITS-1:0]         pixel_row_i,
  output logic                        done_o,
  output logic [7:0]                  grey_level_o
);

  localparam int IW  = mpe_pkg::IW;
  localparam int PPW = mpe_pkg::PPW;
  localparam int PW  = mpe_pkg::PW;
  // Magnitude of pixel index times a 33-bit span.
  localparam int ND  = DIM_BITS + 33;
  localparam int DW  = (ND > 24) ? ND : 24;
  localparam int MW  = (DW + 2 > 42) ? DW + 2 : 42;
  localparam int CW  = (FRAC_BITS + 4 > 42) ? FRAC_BITS + 4 : 42;

  localparam logic signed [CW-1:0] FOUR =
    {{(CW-FRAC_BITS-3){1'b0}}, 3'b100, {FRAC_BITS{1'b0}}};

  mpe_pkg::cfg_t cfg;

  mpe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer state.
  mpe_pkg::state_e state_q, state_d;
  mpe_pkg::step_e  step_q, step_d;
  logic            axis_q, axis_d;

  // Datapath registers.
  logic [DIM_BITS-1:0]         col_q, col_d, row_q, row_d;
  mpe_pkg::inner_t             cr_q, cr_d, ci_q, ci_d;
  mpe_pkg::inner_t             zr_q, zr_d, zi_q, zi_d;
  mpe_pkg::inner_t             rr_q, rr_d, ii_q, ii_d, ri_q, ri_d;
  logic signed [PW-1:0]        acc_q, acc_d;
  logic [mpe_pkg::LIM_W-1:0]   count_q, count_d;
  logic [7:0]                  grey_q, grey_d;
  logic                        done_q, done_d;
  logic                        neg_q, neg_d;

  // Shared units.
  logic                        mul_en;
  logic signed [IW-1:0]        mul_a;
  logic signed [mpe_pkg::BW-1:0] mul_b;
  logic signed [PPW-1:0]       pp;
  logic                        div_start;
  logic [DW-1:0]               div_a;
  logic [mpe_pkg::DIV_VW-1:0]  div_b;
  logic                        div_done;
  logic [DW-1:0]               div_q;

  mpe_mul #(
    .AW (IW),
    .BW (mpe_pkg::BW)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (pp)
  );

  mpe_div #(
    .DW (DW),
    .VW (mpe_pkg::DIV_VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // Helper values.
  logic                        accept;
  logic                        at_limit;
  logic signed [32:0]          span;
  logic [PPW-1:0]              pp_mag;
  logic [23:0]                 scaled;
  logic [mpe_pkg::DIM_W-1:0]   dim_sel;
  logic signed [PW-1:0]        prod_full;
  logic signed [PW-1:0]        prod_sh;
  logic signed [PW-1:0]        prod_hi, prod_lo;
  mpe_pkg::inner_t             prod_sat;
  logic signed [MW-1:0]        map_q, map_lo, map_sum, map_hi_b, map_lo_b;
  mpe_pkg::inner_t             map_c;
  logic signed [CW-1:0]        esc_sum;
  logic                        escaped;

  assign busy     = (state_q != mpe_pkg::ST_IDLE);
  assign accept   = start & ~busy;
  assign at_limit = (count_q >= cfg.iteration_limit);

  // Span of the axis being mapped, exact in 33 bits.
  always_comb begin
    if (axis_q) begin
      span = {cfg.imag_max[31], cfg.imag_max} - {cfg.imag_min[31], cfg.imag_min};
    end else begin
      span = {cfg.real_max[31], cfg.real_max} - {cfg.real_min[31], cfg.real_min};
    end
  end

  assign pp_mag  = pp[PPW-1] ? PPW'(-pp) : pp;
  assign scaled  = {count_q, 8'h00} - {8'h00, count_q};
  assign dim_sel = axis_q ? cfg.image_height : cfg.image_width;

  // Finish a product: combine the two partial products, floor-shift, saturate.
  assign prod_full = acc_q + ({{(PW-PPW){pp[PPW-1]}}, pp} <<< mpe_pkg::HALF);
  assign prod_sh   = prod_full >>> FRAC_BITS;
  assign prod_hi   = {{(PW-IW){1'b0}}, mpe_pkg::SAT_HI};
  assign prod_lo   = {{(PW-IW){1'b1}}, mpe_pkg::SAT_LO};

  always_comb begin
    if (prod_sh > prod_hi) begin
      prod_sat = mpe_pkg::SAT_HI;
    end else if (prod_sh < prod_lo) begin
      prod_sat = mpe_pkg::SAT_LO;
    end else begin
      prod_sat = prod_sh[IW-1:0];
    end
  end

  // Map result: edge plus signed truncated quotient, saturated.
  assign map_q    = neg_q ? -{{(MW-DW){1'b0}}, div_q} : {{(MW-DW){1'b0}}, div_q};
  assign map_lo   = axis_q ? {{(MW-32){cfg.imag_min[31]}}, cfg.imag_min}
                           : {{(MW-32){cfg.real_min[31]}}, cfg.real_min};
  assign map_sum  = map_lo + map_q;
  assign map_hi_b = {{(MW-IW){1'b0}}, mpe_pkg::SAT_HI};
  assign map_lo_b = {{(MW-IW){1'b1}}, mpe_pkg::SAT_LO};

  always_comb begin
    if (map_sum > map_hi_b) begin
      map_c = mpe_pkg::SAT_HI;
    end else if (map_sum < map_lo_b) begin
      map_c = mpe_pkg::SAT_LO;
    end else begin
      map_c = map_sum[IW-1:0];
    end
  end

  // Escape test on the squares of the current z.
  assign esc_sum = {{(CW-IW){rr_q[IW-1]}}, rr_q} + {{(CW-IW){ii_q[IW-1]}}, ii_q};
  assign escaped = (esc_sum >= FOUR);

  // Next state.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    axis_d  = axis_q;
    case (state_q)
      mpe_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = mpe_pkg::ST_MAP_MUL;
          axis_d  = 1'b0;
        end
      end
      mpe_pkg::ST_MAP_MUL: state_d = mpe_pkg::ST_MAP_DIV;
      mpe_pkg::ST_MAP_DIV: state_d = mpe_pkg::ST_MAP_WAIT;
      mpe_pkg::ST_MAP_WAIT: begin
        if (div_done) begin
          if (!axis_q) begin
            axis_d  = 1'b1;
            state_d = mpe_pkg::ST_MAP_MUL;
          end else begin
            state_d = mpe_pkg::ST_ITER;
            step_d  = mpe_pkg::STEP_RR_LO;
          end
        end
      end
      mpe_pkg::ST_ITER: begin
        case (step_q)
          mpe_pkg::STEP_RR_LO: begin
            if (at_limit) begin
              state_d = mpe_pkg::ST_SCALE;
            end else begin
              step_d = mpe_pkg::STEP_RR_HI;
            end
          end
          mpe_pkg::STEP_RI_HI: begin
            if (escaped) begin
              state_d = mpe_pkg::ST_SCALE;
            end else begin
              step_d = mpe_pkg::STEP_RI_DONE;
            end
          end
          mpe_pkg::STEP_UPDATE: step_d = mpe_pkg::STEP_RR_LO;
          default:              step_d = mpe_pkg::step_e'(step_q + 3'd1);
        endcase
      end
      mpe_pkg::ST_SCALE: begin
        state_d = at_limit ? mpe_pkg::ST_IDLE : mpe_pkg::ST_SCALE_WAIT;
      end
      mpe_pkg::ST_SCALE_WAIT: begin
        if (div_done) begin
          state_d = mpe_pkg::ST_IDLE;
        end
      end
      default: state_d = mpe_pkg::ST_IDLE;
    endcase
  end

  // Control outputs to the shared units.
  always_comb begin
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    case (state_q)
      mpe_pkg::ST_MAP_MUL: begin
        mul_en = 1'b1;
        mul_a  = {{(IW-33){span[32]}}, span};
        mul_b  = {{(mpe_pkg::BW-DIM_BITS){1'b0}}, (axis_q ? row_q : col_q)};
      end
      mpe_pkg::ST_MAP_DIV: begin
        div_start = 1'b1;
        div_a     = pp_mag[DW-1:0];
        // A zero image size divides by one.
        div_b     = (dim_sel == '0) ? mpe_pkg::DIV_VW'(1)
                                    : {{(mpe_pkg::DIV_VW-mpe_pkg::DIM_W){1'b0}}, dim_sel};
      end
      mpe_pkg::ST_ITER: begin
        mul_en = 1'b1;
        case (step_q)
          mpe_pkg::STEP_RR_LO: begin
            mul_a = zr_q;
            mul_b = {1'b0, zr_q[mpe_pkg::HALF-1:0]};
          end
          mpe_pkg::STEP_RR_HI: begin
            mul_a = zr_q;
            mul_b = {zr_q[IW-1], zr_q[IW-1:mpe_pkg::HALF]};
          end
          mpe_pkg::STEP_II_LO: begin
            mul_a = zi_q;
            mul_b = {1'b0, zi_q[mpe_pkg::HALF-1:0]};
          end
          mpe_pkg::STEP_II_HI: begin
            mul_a = zi_q;
            mul_b = {zi_q[IW-1], zi_q[IW-1:mpe_pkg::HALF]};
          end
          mpe_pkg::STEP_RI_LO: begin
            mul_a = zr_q;
            mul_b = {1'b0, zi_q[mpe_pkg::HALF-1:0]};
          end
          mpe_pkg::STEP_RI_HI: begin
            mul_a = zr_q;
            mul_b = {zi_q[IW-1], zi_q[IW-1:mpe_pkg::HALF]};
          end
          default: mul_en = 1'b0;
        endcase
      end
      mpe_pkg::ST_SCALE: begin
        div_start = ~at_limit;
        div_a     = {{(DW-24){1'b0}}, scaled};
        div_b     = cfg.iteration_limit;
      end
      default: ;
    endcase
  end

  // Datapath next values.
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    cr_d    = cr_q;
    ci_d    = ci_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    rr_d    = rr_q;
    ii_d    = ii_q;
    ri_d    = ri_q;
    acc_d   = acc_q;
    count_d = count_q;
    grey_d  = grey_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    case (state_q)
      mpe_pkg::ST_IDLE: begin
        if (accept) begin
          col_d = pixel_col_i;
          row_d = pixel_row_i;
        end
      end
      mpe_pkg::ST_MAP_DIV: neg_d = pp[PPW-1];
      mpe_pkg::ST_MAP_WAIT: begin
        if (div_done) begin
          if (!axis_q) begin
            cr_d = map_c;
          end else begin
            ci_d    = map_c;
            zr_d    = '0;
            zi_d    = '0;
            count_d = '0;
          end
        end
      end
      mpe_pkg::ST_ITER: begin
        case (step_q)
          mpe_pkg::STEP_RR_HI,
          mpe_pkg::STEP_II_HI,
          mpe_pkg::STEP_RI_HI:   acc_d = {{(PW-PPW){pp[PPW-1]}}, pp};
          mpe_pkg::STEP_II_LO:   rr_d  = prod_sat;
          mpe_pkg::STEP_RI_LO:   ii_d  = prod_sat;
          mpe_pkg::STEP_RI_DONE: ri_d  = prod_sat;
          mpe_pkg::STEP_UPDATE: begin
            zr_d = mpe_pkg::sat_step({{2{rr_q[IW-1]}}, rr_q} - {{2{ii_q[IW-1]}}, ii_q}
                                     + {{2{cr_q[IW-1]}}, cr_q});
            zi_d = mpe_pkg::sat_step({ri_q[IW-1], ri_q, 1'b0} + {{2{ci_q[IW-1]}}, ci_q});
            count_d = count_q + mpe_pkg::LIM_W'(1);
          end
          default: ;
        endcase
      end
      mpe_pkg::ST_SCALE: begin
        // A point that never escaped is black.
        if (at_limit) begin
          grey_d = '0;
          done_d = 1'b1;
        end
      end
      mpe_pkg::ST_SCALE_WAIT: begin
        if (div_done) begin
          grey_d = div_q[7:0];
          done_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpe_pkg::ST_IDLE;
      step_q  <= mpe_pkg::STEP_RR_LO;
      axis_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      axis_q  <= axis_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    row_q   <= row_d;
    cr_q    <= cr_d;
    ci_q    <= ci_d;
    zr_q    <= zr_d;
    zi_q    <= zi_d;
    rr_q    <= rr_d;
    ii_q    <= ii_d;
    ri_q    <= ri_d;
    acc_q   <= acc_d;
    count_q <= count_d;
    grey_q  <= grey_d;
    neg_q   <= neg_d;
  end

  assign done_o       = done_q;
  assign grey_level_o = grey_q;

endmodule

// ----- design/mpe_checker.sv -----
// Port-level checks for the Mandelbrot pixel escape block, bound to its top.
// Depends only on the ports of mandelbrot_pixel_escape_top.
module mpe_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic pready
);

  // An accepted pixel beat makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("pixel accepted but block not busy");

  // A result only follows a busy period.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a pixel in work");

  // Busy drops only together with the result strobe.
  a_busy_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // The result strobe lasts a single cycle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("configuration port inserted a wait state");

endmodule

bind mandelbrot_pixel_escape_top mpe_checker u_mpe_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .pready (pready)
);
